>>> sv/ssd_pkg.sv
// Shared types, constants and lookup functions for the seven-segment serial driver.
// Used by ssd_digit, ssd_shifter and seven_segment_mux_serial_driver; no dependencies.
package ssd_pkg;

   localparam int DEFAULT_NUM_DIGITS = 4;
   localparam int VALUE_W            = 16;
   localparam int WORD_W             = 16;
   localparam int CNT_W              = 4;
   localparam int MULT_W             = 17;
   localparam int PROD_W             = VALUE_W + MULT_W;
   localparam int SHIFT_W            = 5;
   localparam int QUOT10_W           = 13;

   // Exact reciprocal of ten for any 16-bit dividend.
   localparam logic [MULT_W-1:0]  MOD10_MULT  = 17'd104858;
   localparam int                 MOD10_SHIFT = 20;

   // Largest value that n digits can show; five or more digits never saturate.
   function automatic logic [VALUE_W:0] sat_limit(input int n);
      case (n)
         1:       sat_limit = 17'd9;
         2:       sat_limit = 17'd99;
         3:       sat_limit = 17'd999;
         4:       sat_limit = 17'd9999;
         default: sat_limit = 17'd65535;
      endcase
   endfunction

   // Reciprocal multiplier for 10**exp, exact for any 16-bit dividend.
   // A divisor above the value range yields a zero quotient.
   function automatic logic [MULT_W-1:0] recip_mult(input logic [2:0] exp);
      case (exp)
         3'd0:    recip_mult = 17'd65536;
         3'd1:    recip_mult = 17'd104858;
         3'd2:    recip_mult = 17'd83887;
         3'd3:    recip_mult = 17'd67109;
         3'd4:    recip_mult = 17'd107375;
         default: recip_mult = 17'd0;
      endcase
   endfunction

   function automatic logic [SHIFT_W-1:0] recip_shift(input logic [2:0] exp);
      case (exp)
         3'd0:    recip_shift = 5'd16;
         3'd1:    recip_shift = 5'd20;
         3'd2:    recip_shift = 5'd23;
         3'd3:    recip_shift = 5'd26;
         3'd4:    recip_shift = 5'd30;
         default: recip_shift = 5'd16;
      endcase
   endfunction

   // Active-low segment pattern of one decimal digit.
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      case (digit)
         4'd0:    seg_pattern = 8'hC0;
         4'd1:    seg_pattern = 8'hF9;
         4'd2:    seg_pattern = 8'hA4;
         4'd3:    seg_pattern = 8'hB0;
         4'd4:    seg_pattern = 8'h99;
         4'd5:    seg_pattern = 8'h92;
         4'd6:    seg_pattern = 8'h82;
         4'd7:    seg_pattern = 8'hF8;
         4'd8:    seg_pattern = 8'h80;
         4'd9:    seg_pattern = 8'h90;
         default: seg_pattern = 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] select_byte(input logic [2:0] pos);
      select_byte = 8'hF0 | (8'h01 << pos);
   endfunction

endpackage

>>> sv/ssd_digit.sv
// Digit extraction pipeline: divide by the position's power of ten, take the
// remainder by ten, then look up the 16-bit segment/select word. Uses ssd_pkg.
module ssd_digit import ssd_pkg::*; #(
   parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS,
   parameter int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [VALUE_W-1:0]  in_value,
   input  logic [POS_W-1:0]    in_pos,
   output logic                word_valid,
   input  logic                word_ready,
   output logic [WORD_W-1:0]   word
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [VALUE_W-1:0]    s1_quot_ff, s1_quot_in;
   logic [POS_W-1:0]      s1_pos_ff;
   logic                  s2_valid_ff, s2_valid_in;
   logic [VALUE_W-1:0]    s2_quot_ff;
   logic [QUOT10_W-1:0]   s2_quot10_ff, s2_quot10_in;
   logic [POS_W-1:0]      s2_pos_ff;
   logic                  s3_valid_ff, s3_valid_in;
   logic [WORD_W-1:0]     s3_word_ff, s3_word_in;
   logic                  s1_ready, s2_ready, s3_ready;
   logic [2:0]            exp_val;
   logic [PROD_W-1:0]     prod1, prod2;
   logic [VALUE_W-1:0]    times10, rem_val;

   assign s3_ready = !s3_valid_ff || word_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: quotient by 10**(NUM_DIGITS-1-pos).
   always_comb begin
      exp_val     = 3'(NUM_DIGITS - 1) - 3'(in_pos);
      prod1       = {{MULT_W{1'b0}}, in_value} * {{VALUE_W{1'b0}}, recip_mult(exp_val)};
      s1_quot_in  = VALUE_W'(prod1 >> recip_shift(exp_val));
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   // Stage 2: quotient by ten for the remainder.
   always_comb begin
      prod2        = {{MULT_W{1'b0}}, s1_quot_ff} * {{VALUE_W{1'b0}}, MOD10_MULT};
      s2_quot10_in = prod2[MOD10_SHIFT +: QUOT10_W];
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   // Stage 3: remainder, segment lookup and select byte.
   always_comb begin
      times10     = {s2_quot10_ff, 3'b000} + {2'b00, s2_quot10_ff, 1'b0};
      rem_val     = s2_quot_ff - times10;
      s3_word_in  = {seg_pattern(rem_val[3:0]), select_byte(3'(s2_pos_ff))};
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_quot_ff <= s1_quot_in;
         s1_pos_ff  <= in_pos;
      end
      if (s2_ready) begin
         s2_quot_ff   <= s1_quot_ff;
         s2_quot10_ff <= s2_quot10_in;
         s2_pos_ff    <= s1_pos_ff;
      end
      if (s3_ready) begin
         s3_word_ff <= s3_word_in;
      end
   end

   assign word_valid = s3_valid_ff;
   assign word       = s3_word_ff;

endmodule

>>> sv/ssd_shifter.sv
// Parallel-to-serial stage: sends a 16-bit word MSB first, one bit per beat,
// marking the sixteenth bit. Uses ssd_pkg.
module ssd_shifter import ssd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               word_valid,
   output logic               word_ready,
   input  logic [WORD_W-1:0]  word,
   output logic               bit_valid,
   input  logic               bit_ready,
   output logic               bit_data,
   output logic               bit_last
);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WORD_W-1:0]   shift_ff, shift_in;
   logic                bit_take, load;

   assign bit_take   = busy_ff && bit_ready;
   assign bit_last   = (cnt_ff == CNT_W'(WORD_W - 1));
   assign word_ready = !busy_ff || (bit_take && bit_last);
   assign load       = word_valid && word_ready;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (load) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = word;
      end else if (bit_take) begin
         busy_in  = !bit_last;
         cnt_in   = cnt_ff + CNT_W'(1);
         shift_in = {shift_ff[WORD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign bit_valid = busy_ff;
   assign bit_data  = shift_ff[WORD_W-1];

endmodule

>>> sv/seven_segment_mux_serial_driver.sv
// Top level of the multiplexed seven-segment serial driver.
// Depends on ssd_pkg, ssd_digit and ssd_shifter.
//
// Usage:
//   Each beat on the req_ channel is one refresh tick carrying the number to
//   show in req_tdata. Values above the largest number the digits can hold
//   are shown as that number. The block refreshes one digit per tick,
//   starting with the leftmost after reset and stepping right, wrapping
//   around after the last digit.
//   Each tick yields 16 beats on the rsp_ channel: rsp_tdata bit 0 is the
//   shift-register data bit, segment byte first, then the digit select
//   byte, MSB first. rsp_tlast is high on the sixteenth bit; pulse the latch
//   after that beat.
//   Path: a taken request beat passes the input register, the three
//   extraction stages and the shifter register before its first bit is offered.
//   Throughput: one response beat per cycle while ticks wait and rsp_tready
//   is high, set by the one-bit serial output. A new tick is taken while the
//   previous one is still shifting out; up to four ticks wait in the pipeline.
//   When the receiver drops rsp_tready, the current bit holds and the
//   pipeline fills, then req_tready falls. Reset empties the pipeline and
//   returns the digit pointer to the leftmost digit.
module seven_segment_mux_serial_driver import ssd_pkg::*; #(
   parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [15:0] display_value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // [0] serial_data, [7:1] zero
   output logic         rsp_tlast    // latch_after
);

   localparam int               POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [VALUE_W:0] LIMIT = sat_limit(NUM_DIGITS);

   logic                 in_valid_ff, in_valid_in;
   logic [VALUE_W-1:0]   in_value_ff, in_value_in;
   logic [POS_W-1:0]     in_pos_ff;
   logic [POS_W-1:0]     ptr_ff, ptr_in;
   logic                 digit_ready, req_take;
   logic                 word_valid, word_ready;
   logic [WORD_W-1:0]    word;
   logic                 bit_data;

   assign req_tready = !in_valid_ff || digit_ready;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_value_in = ({1'b0, req_tdata} > LIMIT) ? LIMIT[VALUE_W-1:0] : req_tdata;
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      ptr_in      = ptr_ff;
      if (req_take) begin
         ptr_in = (ptr_ff == POS_W'(NUM_DIGITS - 1)) ? '0 : ptr_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ptr_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         ptr_ff      <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_value_ff <= in_value_in;
         in_pos_ff   <= ptr_ff;
      end
   end

   ssd_digit #(
      .NUM_DIGITS (NUM_DIGITS),
      .POS_W      (POS_W)
   ) u_digit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_ready   (digit_ready),
      .in_value   (in_value_ff),
      .in_pos     (in_pos_ff),
      .word_valid (word_valid),
      .word_ready (word_ready),
      .word       (word)
   );

   ssd_shifter u_shifter (
      .clock      (clock),
      .reset      (reset),
      .word_valid (word_valid),
      .word_ready (word_ready),
      .word       (word),
      .bit_valid  (rsp_tvalid),
      .bit_ready  (rsp_tready),
      .bit_data   (bit_data),
      .bit_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'b0000000, bit_data};

`ifndef SYNTH
   // The digit pointer never leaves the configured digit range.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ptr_ff} <= (POS_W + 1)'(NUM_DIGITS - 1))
      else $error("digit pointer out of range");

   // With more than one digit, every accepted tick moves the pointer on to the next digit.
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (NUM_DIGITS > 1) |=> ptr_ff != $past(ptr_ff))
      else $error("digit pointer did not advance");

   // A sixteen-bit frame goes out without gaps once it has started.
   a_frame_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("serial frame interrupted before its last bit");
`endif

endmodule
